>>> rtl/tef32_pkg.sv
`timescale 1ns / 1ps
// tef32_pkg: shared types and constants for the tensor element to fp32 converter
// no dependencies
package tef32_pkg;
  localparam int RawW = 64;
  localparam int Fp32W = 32;
  localparam int FmtW = 3;
  localparam logic [FmtW-1:0] FMT_FP32 = 3'd0;
  localparam logic [FmtW-1:0] FMT_BF16 = 3'd1;
  localparam logic [FmtW-1:0] FMT_FP16 = 3'd2;
  localparam logic [FmtW-1:0] FMT_E4M3 = 3'd3;
  localparam logic [FmtW-1:0] FMT_INT64 = 3'd4;
  localparam logic [31:0] EXP_ALL_ONES = 32'h7F80_0000;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [7:0] FP16_BIAS_ADJ = 8'd112;
  localparam logic [7:0] E4M3_BIAS_ADJ = 8'd120;

  typedef struct packed {
    logic        sign;
    logic [62:0] mag;
    logic        zero;
  } int_mag_t;
endpackage

>>> rtl/tef32_int_conv.sv
`timescale 1ns / 1ps
// tef32_int_conv: three-stage int64 to fp32 conversion with round to nearest even
// depends on tef32_pkg
module tef32_int_conv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] in_val,
  output logic        out_vld,
  output logic [31:0] out_bits
);
  import tef32_pkg::*;

  int_mag_t    s1_r;
  logic        v1_r, v2_r, v3_r;
  logic        s2_sign_r, s2_zero_r;
  logic [5:0]  s2_p_r;
  logic [63:0] s2_norm_r;
  logic [31:0] s3_r;
  logic [63:0] neg;
  logic [5:0]  p_nxt;
  logic [63:0] norm_nxt;
  logic [23:0] q;
  logic        g, st, up;
  logic [31:0] res_nxt;

  assign neg = 64'd0 - in_val;

  // stage 1: magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_vld;
    s1_r.sign <= in_val[63];
    s1_r.mag <= in_val[63] ? neg[62:0] : in_val[62:0];
    s1_r.zero <= (in_val == 64'd0);
  end

  // stage 2: leading one and normalize
  always_comb begin
    p_nxt = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (i == 63) begin
        if (s1_r.sign && s1_r.mag == 63'd0) p_nxt = 6'd63;
      end else if (s1_r.mag[i]) begin
        p_nxt = 6'(i);
      end
    end
    norm_nxt = {1'b0, s1_r.mag} << (6'd63 - p_nxt);
    if (s1_r.sign && s1_r.mag == 63'd0) norm_nxt = 64'h8000_0000_0000_0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    s2_sign_r <= s1_r.sign;
    s2_zero_r <= s1_r.zero;
    s2_p_r <= p_nxt;
    s2_norm_r <= norm_nxt;
  end

  // stage 3: round and pack
  always_comb begin
    q = s2_norm_r[63:40];
    g = s2_norm_r[39];
    st = |s2_norm_r[38:0];
    up = g && (st || q[0]);
    res_nxt = ({1'b0, 8'(8'd126 + {2'b00, s2_p_r}), 23'd0}) + {8'd0, q} + {31'd0, up};
    res_nxt[31] = s2_sign_r;
    if (s2_zero_r) res_nxt = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    s3_r <= res_nxt;
  end

  assign out_vld = v3_r;
  assign out_bits = s3_r;

`ifndef ASSERT_OFF
  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> ##3 out_vld) else $error("int valid lost");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && s2_zero_r) |=> out_bits == 32'd0) else $error("int zero wrong");
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !s2_zero_r) |-> s2_norm_r[63]) else $error("int not normalized");
`endif
endmodule

>>> rtl/tensor_element_to_fp32_top.sv
`timescale 1ns / 1ps
// tensor_element_to_fp32_top: raw tensor word to fp32 converter, top level
// depends on tef32_pkg and tef32_int_conv
//
// One word is taken every cycle (busy stays low) and its result appears on
// out_fp32_bits with out_valid after the three register stages of the int64
// path (magnitude, normalize, round). Results cannot be held off. Write
// cfg_source_format only while no word is in flight.
module tensor_element_to_fp32_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tef32_pkg::RawW-1:0]  in_raw_element,
  output logic                        out_valid,
  output logic [tef32_pkg::Fp32W-1:0] out_fp32_bits,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tef32_pkg::FmtW-1:0]  cfg_source_format
);
  import tef32_pkg::*;

  logic [FmtW-1:0] fmt_r;
  logic [31:0] sf_nxt, sf1_r, sf2_r, sf3_r;
  logic        int1_r, int2_r, int3_r;
  logic        iv;
  logic [31:0] int_bits;
  logic [15:0] h;
  logic [7:0]  b;
  logic [2:0]  m8;
  logic [1:0]  sh;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) fmt_r <= FMT_FP32;
    else if (cfg_valid) fmt_r <= cfg_source_format;
  end

  always_comb begin
    h = in_raw_element[15:0];
    b = in_raw_element[7:0];
    m8 = b[2:0];
    sh = m8[2] ? 2'd0 : (m8[1] ? 2'd1 : 2'd2);
    sf_nxt = 32'd0;
    unique case (fmt_r)
      FMT_FP32: sf_nxt = in_raw_element[31:0];
      FMT_BF16: sf_nxt = {h, 16'd0};
      FMT_FP16: begin
        if (h[14:10] == 5'd0) sf_nxt = {h[15], 31'd0};
        else if (h[14:10] == 5'd31) sf_nxt = {h[15], 31'd0} | EXP_ALL_ONES | {9'd0, h[9:0], 13'd0};
        else sf_nxt = {h[15], 8'({3'd0, h[14:10]} + FP16_BIAS_ADJ), h[9:0], 13'd0};
      end
      FMT_E4M3: begin
        if (b[6:3] == 4'd0) begin
          if (m8 == 3'd0) sf_nxt = {b[7], 31'd0};
          else sf_nxt = {b[7], 8'(E4M3_BIAS_ADJ - {6'd0, sh}), 2'(m8 << sh), 21'd0};
        end else if (b[6:0] == 7'h7F) sf_nxt = {b[7], 31'd0} | QNAN;
        else sf_nxt = {b[7], 8'({4'd0, b[6:3]} + E4M3_BIAS_ADJ), m8, 20'd0};
      end
      default: sf_nxt = 32'd0;
    endcase
  end

  tef32_int_conv u_int (
    .clk(clk), .rst_n(rst_n), .in_vld(start), .in_val(in_raw_element),
    .out_vld(iv), .out_bits(int_bits)
  );

  // short formats ride alongside the int64 stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int1_r <= 1'b0;
      int2_r <= 1'b0;
      int3_r <= 1'b0;
    end else begin
      int1_r <= (fmt_r == FMT_INT64);
      int2_r <= int1_r;
      int3_r <= int2_r;
    end
    sf1_r <= sf_nxt;
    sf2_r <= sf1_r;
    sf3_r <= sf2_r;
  end

  assign out_valid = iv;
  assign out_fp32_bits = int3_r ? int_bits : sf3_r;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##3 out_valid) else $error("word lost");
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3)) else $error("word invented");
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif
endmodule

>>> bench/tensor_element_to_fp32_top_test.sv
`timescale 1ns / 1ps
// tensor_element_to_fp32_top_test: self-checking bench for the raw element to fp32 converter
// depends on tef32_pkg and tensor_element_to_fp32_top; drives words per format, checks every result
module tensor_element_to_fp32_top_test;
  import tef32_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [RawW-1:0] in_raw_element;
  logic out_valid;
  logic [Fp32W-1:0] out_fp32_bits;
  logic cfg_valid;
  logic cfg_ready;
  logic [FmtW-1:0] cfg_source_format;

  logic [RawW-1:0] pending_words[$];
  logic [Fp32W-1:0] expected_fp32[$];
  logic [FmtW-1:0] cur_format;
  logic [FmtW-1:0] cfg_target;
  bit cfg_request;
  bit cfg_done;
  int gap_left;
  int errors;

  tensor_element_to_fp32_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_raw_element(in_raw_element), .out_valid(out_valid), .out_fp32_bits(out_fp32_bits),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_source_format(cfg_source_format)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] fp16_to_fp32(logic [15:0] h);
    logic [31:0] s;
    logic [4:0] e;
    logic [9:0] m;
    s = {h[15], 31'd0};
    e = h[14:10];
    m = h[9:0];
    if (e == 5'd0) return s;
    if (e == 5'd31) return s | EXP_ALL_ONES | ({22'd0, m} << 13);
    return s | ({24'd0, 3'd0, e} + 32'd112) << 23 | ({22'd0, m} << 13);
  endfunction

  function automatic logic [31:0] e4m3_to_fp32(logic [7:0] b);
    logic [31:0] s;
    logic [3:0] e;
    logic [2:0] m;
    int sh;
    s = {b[7], 31'd0};
    e = b[6:3];
    m = b[2:0];
    sh = 0;
    if (e == 4'd0) begin
      if (m == 3'd0) return s;
      while (!m[2] && sh < 3) begin
        m = m << 1;
        sh++;
      end
      return s | ((32'd120 - sh) << 23) | ({30'd0, m[1:0]} << 21);
    end
    if (e == 4'd15 && m == 3'd7) return s | QNAN;
    return s | (({28'd0, e} + 32'd120) << 23) | ({29'd0, m} << 20);
  endfunction

  function automatic logic [31:0] int64_to_fp32(logic [63:0] v);
    logic [31:0] s;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    int p;
    int sh;
    s = 32'd0;
    mag = v;
    p = 0;
    if (v[63]) begin
      s = 32'h8000_0000;
      mag = 64'd0 - v;
    end
    if (mag == 64'd0) return s;
    while (p < 63 && (mag >> (p + 1)) != 64'd0) p++;
    if (p <= 23) begin
      q = mag << (23 - p);
    end else begin
      sh = p - 23;
      rem = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q = mag >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end
    return s | 32'(((64'd126 + 64'(p)) << 23) + q);
  endfunction

  function automatic logic [31:0] convert_word(logic [FmtW-1:0] fmt, logic [63:0] raw);
    case (fmt)
      FMT_FP32: return raw[31:0];
      FMT_BF16: return {raw[15:0], 16'd0};
      FMT_FP16: return fp16_to_fp32(raw[15:0]);
      FMT_E4M3: return e4m3_to_fp32(raw[7:0]);
      FMT_INT64: return int64_to_fp32(raw);
      default: return 32'd0;
    endcase
  endfunction

  task automatic queue_word(input logic [63:0] w);
    pending_words.insert(pending_words.size(), w);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_valid <= 1'b0;
        cur_format <= cfg_source_format;
        cfg_done <= 1'b1;
      end else if (cfg_request && !cfg_valid && !cfg_done) begin
        cfg_valid <= 1'b1;
        cfg_source_format <= cfg_target;
      end
      if (start && !busy) begin
        expected_fp32.insert(expected_fp32.size(), convert_word(cur_format, in_raw_element));
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0 && !cfg_request) begin
        start <= 1'b1;
        in_raw_element <= pending_words.pop_front();
        gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_fp32.size() == 0) begin
        $error("unexpected word fp32_bits actual %h", out_fp32_bits);
        errors++;
      end else begin
        if (out_fp32_bits !== expected_fp32[0]) begin
          $error("fp32_bits expected %h actual %h", expected_fp32[0], out_fp32_bits);
          errors++;
        end
        void'(expected_fp32.pop_front());
      end
    end
  end

  task automatic set_format(input logic [FmtW-1:0] fmt);
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (start || expected_fp32.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_target = fmt;
    cfg_done = 1'b0;
    cfg_request = 1'b1;
    while (!cfg_done) @(posedge clk);
    cfg_request = 1'b0;
  endtask

  function automatic logic [63:0] rand_word(logic [FmtW-1:0] fmt);
    logic [63:0] w;
    int bits;
    w = {$urandom, $urandom};
    if (fmt == FMT_INT64) begin
      case ($urandom_range(0, 4))
        0: begin
          bits = $urandom_range(1, 63);
          w = w >> (64 - bits);
        end
        1: w = -(w >> $urandom_range(1, 63));
        2: w = w & ~((64'd1 << $urandom_range(1, 40)) - 1) | (64'd1 << $urandom_range(0, 39));
        default: ;
      endcase
    end else if (fmt == FMT_E4M3 && $urandom_range(0, 3) == 0) begin
      w[6:0] = {$urandom_range(0, 1) ? 4'hF : 4'h0, 3'($urandom_range(0, 7))};
    end else if (fmt == FMT_FP16 && $urandom_range(0, 3) == 0) begin
      w[14:10] = $urandom_range(0, 1) ? 5'h1F : 5'h00;
    end
    return w;
  endfunction

  initial begin
    logic [FmtW-1:0] fmts[8];
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_source_format = FMT_FP32;
    in_raw_element = '0;
    cur_format = FMT_FP32;
    cfg_request = 1'b0;
    cfg_done = 1'b0;
    errors = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    fmts = '{FMT_FP32, FMT_BF16, FMT_FP16, FMT_E4M3, FMT_INT64, 3'd5, 3'd7, FMT_INT64};
    // directed words at reset format then per format
    queue_word(64'hFFFF_FFFF_FFFF_FFFF);
    queue_word(64'h0);
    set_format(FMT_BF16);
    queue_word(64'hFFFF_FFFF_FFFF_8001);
    set_format(FMT_FP16);
    queue_word(64'h0000_0000_0000_83FF);
    queue_word(64'hFFFF_FFFF_FFFF_7C00);
    queue_word(64'h0000_0000_0000_FE01);
    queue_word(64'h0000_0000_0000_3C00);
    set_format(FMT_E4M3);
    queue_word(64'h7F);
    queue_word(64'hFFFF_FFFF_FFFF_FF7F);
    queue_word(64'h7E);
    queue_word(64'h01);
    queue_word(64'h83);
    queue_word(64'h06);
    queue_word(64'h80);
    set_format(FMT_INT64);
    queue_word(64'h0);
    queue_word(64'h8000_0000_0000_0000);
    queue_word(64'h7FFF_FFFF_FFFF_FFFF);
    queue_word(64'hFFFF_FFFF_FFFF_FFFF);
    queue_word(64'h0000_0000_0100_0001);
    queue_word(64'h0000_0000_0100_0003);
    queue_word(64'h0000_0000_00FF_FFFF);
    set_format(3'd6);
    queue_word(64'h1234_5678_9ABC_DEF0);
    // random phases
    for (int ph = 0; ph < 19; ph++) begin
      logic [FmtW-1:0] f;
      f = (ph % 6 == 5) ? 3'($urandom_range(5, 7)) : fmts[$urandom_range(0, 4)];
      if (ph == 18) f = FMT_FP32;
      set_format(f);
      for (int k = 0; k < 100; k++) queue_word(rand_word(f));
    end
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (start || expected_fp32.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
